/* hdl/pmsd_pkg.sv */
// ----------------------------------------------------------------------------
// pmsd_pkg
// Types and constants shared by the mode switch debouncer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pmsd_pkg;

    localparam int WIDTH_W  = 12;
    localparam int MODE_W   = 8;
    localparam int NUM_REGS = 7;
    localparam int NUM_BANDS = 6;
    localparam int REG_IDX_W = 3;

    typedef logic [WIDTH_W-1:0] width_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [NUM_REGS-1:0][MODE_W-1:0] mode_table_t;

    localparam reg_idx_t REG_FALLBACK = 3'd6;

    localparam mode_t MODE_RESET     = 8'd0;
    localparam mode_t FALLBACK_RESET = 8'd11;

    localparam width_t BAND_LOW = 12'd900;
    localparam width_t BAND_UPPER [NUM_BANDS] = '{
        12'd1230, 12'd1360, 12'd1490, 12'd1620, 12'd1750, 12'd2200
    };

endpackage

`default_nettype wire

/* hdl/pmsd_band_sel.sv */
// ----------------------------------------------------------------------------
// pmsd_band_sel
// Sorts a pulse width into a switch band and selects its mode code.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsd_band_sel (
    input  wire pmsd_pkg::width_t      pulse_width,
    input  wire pmsd_pkg::mode_table_t mode_table,
    output pmsd_pkg::mode_t            sel_mode
);

    always_comb begin
        logic found;
        found = 1'b0;
        sel_mode = mode_table[pmsd_pkg::REG_FALLBACK];
        if (pulse_width >= pmsd_pkg::BAND_LOW) begin
            for (int i = 0; i < pmsd_pkg::NUM_BANDS; i++) begin
                if (!found && (pulse_width < pmsd_pkg::BAND_UPPER[i])) begin
                    sel_mode = mode_table[i];
                    found = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/pmsd_debounce.sv */
// ----------------------------------------------------------------------------
// pmsd_debounce
// Holds the stable mode, the candidate mode and the confirmation count,
// and updates them once for each selected mode code.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsd_debounce #(
    parameter int CONFIRM_LIMIT = 3
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   update_en,
    input  wire pmsd_pkg::mode_t  sel_mode,
    output pmsd_pkg::mode_t       stable_next
);

    localparam int CNT_W = $clog2(CONFIRM_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CONFIRM_LIMIT);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    pmsd_pkg::mode_t  stable_reg, stable_reg_next;
    pmsd_pkg::mode_t  cand_reg, cand_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        stable_reg_next = stable_reg;
        cand_next = cand_reg;
        count_next = count_reg;
        if (sel_mode != stable_reg) begin
            if (sel_mode == cand_reg) begin
                if (count_reg >= CNT_LIMIT) begin
                    stable_reg_next = cand_reg;
                    count_next = '0;
                end else begin
                    count_next = count_reg + CNT_ONE;
                end
            end else if (count_reg == '0) begin
                cand_next = sel_mode;
                count_next = CNT_ONE;
            end else begin
                cand_next = stable_reg;
                count_next = '0;
            end
        end
    end

    assign stable_next = stable_reg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= pmsd_pkg::FALLBACK_RESET;
            cand_reg <= pmsd_pkg::FALLBACK_RESET;
            count_reg <= '0;
        end else if (update_en) begin
            stable_reg <= stable_reg_next;
            cand_reg <= cand_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/pwm_mode_switch_debouncer.sv */
// ----------------------------------------------------------------------------
// pwm_mode_switch_debouncer
// Debounces a radio-control mode switch given as pulse widths.
//
// Each request on the s_ channel carries one pulse width in microseconds.
// The width is captured in an input register, sorted into a switch band,
// mapped to the mode code held in the configuration registers, and passed
// through the debounce state. Each request yields one m_ request with the
// stable mode code in force after that width.
// m_valid rises once the width has passed the input register and the output register,
// which form a two-stage pipeline. A new width is taken every cycle while the receiver
// does not stall, and s_ready follows m_ready combinationally.
// When the receiver stalls, the output register holds its result and the
// input register fills; s_ready then falls until m_ready returns.
// Reset clears both stages, sets the stable and candidate modes to 11,
// the band mode codes to 0 and the fallback code to 11.
// Configuration writes through cfg_wen apply to every width not yet past the input register;
// indexes beyond the fallback register are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_mode_switch_debouncer #(
    parameter int CONFIRM_LIMIT = 3
) (
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        s_valid,
    output logic       s_ready,
    input  wire [11:0] s_pulse_width,

    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_stable_mode_out,

    input  wire        cfg_wen,
    input  wire [2:0]  cfg_index,
    input  wire [7:0]  cfg_wdata
);

    pmsd_pkg::mode_table_t mode_table_reg;
    pmsd_pkg::width_t      width_reg;
    logic                  in_valid_reg;
    pmsd_pkg::mode_t       out_mode_reg;
    logic                  out_valid_reg;

    pmsd_pkg::mode_t       sel_mode;
    pmsd_pkg::mode_t       stable_next;
    logic                  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_stable_mode_out = out_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pmsd_pkg::NUM_BANDS; i++) begin
                mode_table_reg[i] <= pmsd_pkg::MODE_RESET;
            end
            mode_table_reg[pmsd_pkg::REG_FALLBACK] <= pmsd_pkg::FALLBACK_RESET;
        end else if (cfg_wen && (cfg_index <= pmsd_pkg::REG_FALLBACK)) begin
            mode_table_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            width_reg <= s_pulse_width;
        end
        if (advance) begin
            out_mode_reg <= stable_next;
        end
    end

    pmsd_band_sel u_band_sel (
        .pulse_width (width_reg),
        .mode_table  (mode_table_reg),
        .sel_mode    (sel_mode)
    );

    pmsd_debounce #(
        .CONFIRM_LIMIT (CONFIRM_LIMIT)
    ) u_debounce (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .update_en   (advance),
        .sel_mode    (sel_mode),
        .stable_next (stable_next)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PWM mode switch debouncer.
//
// Pulse widths are sent as requests on the s_ channel, and the stable mode
// codes come back on the m_ channel. A predictor inside the bench sorts each
// accepted width into its switch band, maps the band to its mode code, and
// runs the debounce state. Each returned code is checked against the oldest
// predicted code. A short directed table covers band edges, out-of-band
// widths, a debounce commit and a write to the spare register index. Random
// runs of readings from one band then follow under several register
// settings, with random gaps on both channels under all but the last setting.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int DEBOUNCE_LIMIT = 3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_WIDTHS   = 367;
    localparam int DIR_ROWS       = 25;
    localparam int DIR_CFG_AT     = 9;

    localparam pmsd_pkg::reg_idx_t REG_BAND0 = 3'd0;
    localparam pmsd_pkg::reg_idx_t REG_SPARE = 3'd7;

    typedef pmsd_pkg::mode_t reg_image_t [REG_SPARE+1];

    typedef struct packed {
        pmsd_pkg::width_t width;
        logic             typed;
        pmsd_pkg::mode_t  want;
    } dir_row_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    pmsd_pkg::width_t   s_pulse_width = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    pmsd_pkg::mode_t    m_stable_mode_out;
    logic               cfg_wen       = 1'b0;
    pmsd_pkg::reg_idx_t cfg_index     = REG_BAND0;
    pmsd_pkg::mode_t    cfg_wdata     = '0;

    logic               row_typed     = 1'b0;
    pmsd_pkg::mode_t    row_want      = '0;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         failures      = 0;
    int         cycles        = 0;
    int         widths_sent   = 0;
    int         switches      = 0;

    pmsd_pkg::mode_t code_tbl [pmsd_pkg::NUM_REGS];
    pmsd_pkg::mode_t held_mode;
    pmsd_pkg::mode_t cand_mode;
    int              confirm_cnt;
    pmsd_pkg::mode_t pending_modes [$];

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{12'd0,    1'b1, pmsd_pkg::FALLBACK_RESET},
        '{12'd4095, 1'b1, pmsd_pkg::FALLBACK_RESET},
        '{12'd900,  1'b1, pmsd_pkg::FALLBACK_RESET},
        '{12'd1229, 1'b1, pmsd_pkg::FALLBACK_RESET},
        '{12'd1000, 1'b1, pmsd_pkg::FALLBACK_RESET},
        '{12'd1100, 1'b1, pmsd_pkg::MODE_RESET},
        '{12'd899,  1'b1, pmsd_pkg::MODE_RESET},
        '{12'd1230, 1'b1, pmsd_pkg::MODE_RESET},
        '{12'd2200, 1'b1, pmsd_pkg::MODE_RESET},
        '{12'd1229, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1230, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1359, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1360, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1490, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1619, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1620, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1749, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd1750, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd2199, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd2199, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd2199, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd2199, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd2200, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd4095, 1'b0, pmsd_pkg::MODE_RESET},
        '{12'd2048, 1'b0, pmsd_pkg::MODE_RESET}
    };

    pwm_mode_switch_debouncer #(
        .CONFIRM_LIMIT(DEBOUNCE_LIMIT)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pulse_width     (s_pulse_width),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_stable_mode_out (m_stable_mode_out),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic pmsd_pkg::mode_t band_code(input pmsd_pkg::width_t w);
        if (w < pmsd_pkg::BAND_LOW) begin
            return code_tbl[pmsd_pkg::REG_FALLBACK];
        end
        for (int b = 0; b < pmsd_pkg::NUM_BANDS; b++) begin
            if (w < pmsd_pkg::BAND_UPPER[b]) begin
                return code_tbl[b];
            end
        end
        return code_tbl[pmsd_pkg::REG_FALLBACK];
    endfunction

    function automatic void debounce_step(input pmsd_pkg::width_t w);
        pmsd_pkg::mode_t sel;
        sel = band_code(w);
        if (sel != held_mode) begin
            if (sel == cand_mode) begin
                if (confirm_cnt >= DEBOUNCE_LIMIT) begin
                    held_mode   = cand_mode;
                    confirm_cnt = 0;
                    switches++;
                end else begin
                    confirm_cnt++;
                end
            end else if (confirm_cnt == 0) begin
                cand_mode   = sel;
                confirm_cnt = 1;
            end else begin
                cand_mode   = held_mode;
                confirm_cnt = 0;
            end
        end
    endfunction

    always @(posedge aclk) begin
        pmsd_pkg::mode_t want;
        if (!aresetn) begin
            for (int i = REG_BAND0; i < pmsd_pkg::REG_FALLBACK; i++) begin
                code_tbl[i] = pmsd_pkg::MODE_RESET;
            end
            code_tbl[pmsd_pkg::REG_FALLBACK] = pmsd_pkg::FALLBACK_RESET;
            held_mode   = pmsd_pkg::FALLBACK_RESET;
            cand_mode   = pmsd_pkg::FALLBACK_RESET;
            confirm_cnt = 0;
            pending_modes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_modes.size() == 0) begin
                    $display("%0t: unexpected mode code %0d with no request pending",
                             $time, m_stable_mode_out);
                    failures++;
                end else begin
                    want = pending_modes.pop_front();
                    if (m_stable_mode_out !== want) begin
                        $display("%0t: stable mode expected %0d, got %0d",
                                 $time, want, m_stable_mode_out);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                debounce_step(s_pulse_width);
                pending_modes.push_back(row_typed ? row_want : held_mode);
                widths_sent++;
            end
            if (cfg_wen && cfg_index <= pmsd_pkg::REG_FALLBACK) begin
                code_tbl[cfg_index] = cfg_wdata;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[pwm_mode_switch_debouncer] ERROR");
            $finish;
        end
    end

    task automatic send_width(input pmsd_pkg::width_t w, input logic typed,
                              input pmsd_pkg::mode_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pulse_width <= w;
        row_typed     <= typed;
        row_want      <= want;
        @(posedge aclk);
        while (!(s_valid && s_ready)) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_modes.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_modes(input reg_image_t image);
        for (int i = REG_BAND0; i <= REG_SPARE; i++) begin
            cfg_wen   <= 1'b1;
            cfg_index <= pmsd_pkg::reg_idx_t'(i);
            cfg_wdata <= image[i];
            @(negedge aclk);
        end
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        reg_image_t       image;
        int               band;
        int               run_len;
        int               left;
        pmsd_pkg::width_t lo;
        pmsd_pkg::width_t hi;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 37;
        recv_stall_pct = 80;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == DIR_CFG_AT) begin
                settle();
                image = '{8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'h00, 8'h5A};
                load_modes(image);
            end
            send_width(dir_rows[r].width, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            settle();
            send_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 80 : 0;
            recv_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 37 : 0;
            for (int i = REG_BAND0; i <= REG_SPARE; i++) begin
                case (ph)
                    0: image[i] = pmsd_pkg::mode_t'($urandom_range(0, 255));
                    1: image[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: image[i] = pmsd_pkg::mode_t'($urandom_range(0, 3));
                endcase
            end
            load_modes(image);
            left = PHASE_WIDTHS;
            while (left > 0) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_width(pmsd_pkg::width_t'($urandom_range(0, 4095)), 1'b0,
                               pmsd_pkg::MODE_RESET);
                    left--;
                end else begin
                    band    = $urandom_range(0, pmsd_pkg::NUM_BANDS + 1);
                    run_len = $urandom_range(1, 6);
                    if (band == pmsd_pkg::NUM_BANDS) begin
                        lo = '0;
                        hi = pmsd_pkg::width_t'(pmsd_pkg::BAND_LOW - 1);
                    end else if (band == pmsd_pkg::NUM_BANDS + 1) begin
                        lo = pmsd_pkg::BAND_UPPER[pmsd_pkg::NUM_BANDS-1];
                        hi = '1;
                    end else begin
                        lo = (band == 0) ? pmsd_pkg::BAND_LOW
                                         : pmsd_pkg::BAND_UPPER[band-1];
                        hi = pmsd_pkg::width_t'(pmsd_pkg::BAND_UPPER[band] - 1);
                    end
                    for (int k = 0; k < run_len && left > 0; k++) begin
                        send_width(pmsd_pkg::width_t'($urandom_range(lo, hi)), 1'b0,
                                   pmsd_pkg::MODE_RESET);
                        left--;
                    end
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_modes.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);

        $display("Sent %0d pulse widths under five mode code settings; %0d mode switches taken.",
                 widths_sent, switches);
        if (failures == 0) begin
            $display("[pwm_mode_switch_debouncer] OK");
        end else begin
            $display("[pwm_mode_switch_debouncer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
